// ===== rtl/core/sam_pkg.sv =====
`default_nettype none
package sam_pkg;

    localparam int MaxNodes  = 8192;
    localparam int Alphabet  = 26;
    localparam int NodeW     = $clog2(MaxNodes);
    localparam int SymW      = 5;
    localparam int OutDataW  = 72;
    localparam int InDataW   = 8;

    typedef logic [NodeW-1:0] t_node;

    // One node record: longest length, suffix link and all transitions.
    typedef struct packed {
        t_node                      len;
        t_node                      link;
        logic [Alphabet-1:0][NodeW-1:0] nxt;
    } t_rec;

    typedef struct packed {
        logic  we;
        t_node waddr;
        t_rec  wdata;
        logic  re;
        t_node raddr;
    } t_mem_req;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_WALK,
        ST_QCHK,
        ST_CLQ,
        ST_REDIR,
        ST_RLOAD,
        ST_FIN,
        ST_OUT
    } t_state;

endpackage
`default_nettype wire

// ===== rtl/core/sam_node_ram.sv =====
`default_nettype none
module sam_node_ram (
    input  wire logic              i_clk,
    input  wire sam_pkg::t_mem_req i_req,
    output sam_pkg::t_rec          o_rdata
);

    sam_pkg::t_rec r_mem [sam_pkg::MaxNodes];
    sam_pkg::t_rec r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== rtl/core/sam_ctrl.sv =====
`default_nettype none
module sam_ctrl (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_s_tvalid,
    output logic                                o_s_tready,
    input  wire logic [sam_pkg::InDataW-1:0]    i_s_tdata,   // [4:0] symbol
    output logic                                o_m_tvalid,
    input  wire logic                           i_m_tready,
    // [12:0] new_node, [25:13] new_length, [38:26] new_link, [39] did_clone,
    // [52:40] clone_node, [65:53] node_count, rest zero
    output logic [sam_pkg::OutDataW-1:0]        o_m_tdata,
    output logic                                o_m_tuser,   // [0] full_res
    output sam_pkg::t_mem_req                   o_req,
    input  wire sam_pkg::t_rec                  i_rdata
);

    localparam int W = sam_pkg::NodeW;

    sam_pkg::t_state r_state, n_state;
    logic [sam_pkg::SymW-1:0] r_sym, n_sym;
    sam_pkg::t_node r_p, n_p, r_cur, n_cur, r_q, n_q, r_cl, n_cl;
    sam_pkg::t_node r_lenp, n_lenp, r_curlen, n_curlen, r_linkcur, n_linkcur;
    sam_pkg::t_node r_top, n_top, r_last, n_last;
    sam_pkg::t_rec  r_prec, n_prec;
    logic r_first, n_first, r_clone, n_clone;

    sam_pkg::t_node r_o_node, r_o_len, r_o_link, r_o_clnode, r_o_count;
    sam_pkg::t_node n_o_node, n_o_len, n_o_link, n_o_clnode, n_o_count;
    logic r_o_clone, r_o_full, n_o_clone, n_o_full;

    logic [sam_pkg::SymW-1:0] in_sym;
    logic sym_bad, store_full, accept;
    sam_pkg::t_node edge_rd, edge_prec;
    sam_pkg::t_rec  rec_mod;

    assign in_sym     = i_s_tdata[sam_pkg::SymW-1:0];
    assign sym_bad    = in_sym >= sam_pkg::SymW'(sam_pkg::Alphabet);
    assign store_full = ({1'b0, r_top} + (W+1)'(2)) >= (W+1)'(sam_pkg::MaxNodes);
    assign accept     = i_s_tvalid && o_s_tready;
    assign edge_rd    = i_rdata.nxt[r_sym];
    assign edge_prec  = r_prec.nxt[r_sym];

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sam_pkg::ST_INIT: n_state = sam_pkg::ST_IDLE;
            sam_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = (sym_bad || store_full) ? sam_pkg::ST_OUT : sam_pkg::ST_WALK;
                end
            end
            sam_pkg::ST_WALK: begin
                if (edge_rd != '0) begin
                    n_state = sam_pkg::ST_QCHK;
                end else if (i_rdata.link == '0) begin
                    n_state = sam_pkg::ST_FIN;
                end
            end
            sam_pkg::ST_QCHK: begin
                n_state = (r_lenp + W'(1) == i_rdata.len) ? sam_pkg::ST_FIN
                                                         : sam_pkg::ST_CLQ;
            end
            sam_pkg::ST_CLQ:  n_state = sam_pkg::ST_REDIR;
            sam_pkg::ST_REDIR: begin
                if (edge_prec != r_q || r_prec.link == '0) begin
                    n_state = sam_pkg::ST_FIN;
                end else begin
                    n_state = sam_pkg::ST_RLOAD;
                end
            end
            sam_pkg::ST_RLOAD: n_state = sam_pkg::ST_REDIR;
            sam_pkg::ST_FIN:   n_state = sam_pkg::ST_OUT;
            sam_pkg::ST_OUT: begin
                if (i_m_tready) begin
                    n_state = sam_pkg::ST_IDLE;
                end
            end
            default: n_state = sam_pkg::ST_INIT;
        endcase
    end

    // outputs and datapath
    always_comb begin
        o_req      = '0;
        rec_mod    = i_rdata;
        n_sym      = r_sym;
        n_p        = r_p;
        n_cur      = r_cur;
        n_q        = r_q;
        n_cl       = r_cl;
        n_lenp     = r_lenp;
        n_curlen   = r_curlen;
        n_linkcur  = r_linkcur;
        n_top      = r_top;
        n_last     = r_last;
        n_prec     = r_prec;
        n_first    = r_first;
        n_clone    = r_clone;
        n_o_node   = r_o_node;
        n_o_len    = r_o_len;
        n_o_link   = r_o_link;
        n_o_clnode = r_o_clnode;
        n_o_count  = r_o_count;
        n_o_clone  = r_o_clone;
        n_o_full   = r_o_full;
        o_s_tready = (r_state == sam_pkg::ST_IDLE);
        o_m_tvalid = (r_state == sam_pkg::ST_OUT);

        unique case (r_state)
            sam_pkg::ST_INIT: begin
                // root record: length 0, no link, no transitions
                o_req.we    = 1'b1;
                o_req.waddr = W'(1);
                o_req.wdata = '0;
            end
            sam_pkg::ST_IDLE: begin
                if (accept) begin
                    n_sym      = in_sym;
                    n_o_node   = '0;
                    n_o_len    = '0;
                    n_o_link   = '0;
                    n_o_clone  = 1'b0;
                    n_o_clnode = '0;
                    n_o_count  = r_top;
                    n_o_full   = !sym_bad && store_full;
                    n_p        = r_last;
                    n_cur      = r_top + W'(1);
                    n_cl       = r_top + W'(2);
                    n_first    = 1'b1;
                    n_clone    = 1'b0;
                    o_req.re    = !(sym_bad || store_full);
                    o_req.raddr = r_last;
                end
            end
            sam_pkg::ST_WALK: begin
                n_first = 1'b0;
                if (r_first) begin
                    n_curlen = i_rdata.len + W'(1);
                end
                if (edge_rd != '0) begin
                    n_q         = edge_rd;
                    n_prec      = i_rdata;
                    n_lenp      = i_rdata.len;
                    o_req.re    = 1'b1;
                    o_req.raddr = edge_rd;
                end else begin
                    rec_mod.nxt[r_sym] = r_cur;
                    o_req.we    = 1'b1;
                    o_req.waddr = r_p;
                    o_req.wdata = rec_mod;
                    n_p         = i_rdata.link;
                    if (i_rdata.link == '0) begin
                        n_linkcur = W'(1);
                    end else begin
                        o_req.re    = 1'b1;
                        o_req.raddr = i_rdata.link;
                    end
                end
            end
            sam_pkg::ST_QCHK: begin
                if (r_lenp + W'(1) == i_rdata.len) begin
                    n_linkcur = r_q;
                end else begin
                    // clone takes q's link and transitions
                    rec_mod.len  = r_lenp + W'(1);
                    o_req.we     = 1'b1;
                    o_req.waddr  = r_cl;
                    o_req.wdata  = rec_mod;
                    n_clone      = 1'b1;
                    n_linkcur    = r_cl;
                end
            end
            sam_pkg::ST_CLQ: begin
                rec_mod.link = r_cl;
                o_req.we     = 1'b1;
                o_req.waddr  = r_q;
                o_req.wdata  = rec_mod;
            end
            sam_pkg::ST_REDIR: begin
                if (edge_prec == r_q) begin
                    rec_mod            = r_prec;
                    rec_mod.nxt[r_sym] = r_cl;
                    o_req.we    = 1'b1;
                    o_req.waddr = r_p;
                    o_req.wdata = rec_mod;
                    n_p         = r_prec.link;
                    if (r_prec.link != '0) begin
                        o_req.re    = 1'b1;
                        o_req.raddr = r_prec.link;
                    end
                end
            end
            sam_pkg::ST_RLOAD: begin
                n_prec = i_rdata;
            end
            sam_pkg::ST_FIN: begin
                o_req.we         = 1'b1;
                o_req.waddr      = r_cur;
                o_req.wdata      = '0;
                o_req.wdata.len  = r_curlen;
                o_req.wdata.link = r_linkcur;
                n_last     = r_cur;
                n_top      = r_clone ? r_cl : r_cur;
                n_o_node   = r_cur;
                n_o_len    = r_curlen;
                n_o_link   = r_linkcur;
                n_o_clone  = r_clone;
                n_o_clnode = r_clone ? r_cl : '0;
                n_o_count  = r_clone ? r_cl : r_cur;
                n_o_full   = 1'b0;
            end
            sam_pkg::ST_OUT: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sam_pkg::ST_INIT;
            r_top   <= W'(1);
            r_last  <= W'(1);
            r_first <= 1'b0;
            r_clone <= 1'b0;
        end else begin
            r_state <= n_state;
            r_top   <= n_top;
            r_last  <= n_last;
            r_first <= n_first;
            r_clone <= n_clone;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sym      <= n_sym;
        r_p        <= n_p;
        r_cur      <= n_cur;
        r_q        <= n_q;
        r_cl       <= n_cl;
        r_lenp     <= n_lenp;
        r_curlen   <= n_curlen;
        r_linkcur  <= n_linkcur;
        r_prec     <= n_prec;
        r_o_node   <= n_o_node;
        r_o_len    <= n_o_len;
        r_o_link   <= n_o_link;
        r_o_clnode <= n_o_clnode;
        r_o_count  <= n_o_count;
        r_o_clone  <= n_o_clone;
        r_o_full   <= n_o_full;
    end

    assign o_m_tdata = {6'd0, r_o_count, r_o_clnode, r_o_clone, r_o_link, r_o_len, r_o_node};
    assign o_m_tuser = r_o_full;

    a_last_le_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_last <= r_top) else $error("last node beyond top node");
    a_clone_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && r_o_clone) |-> (r_o_clnode == r_o_node + W'(1)))
        else $error("clone index not next to new node");
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_req.we && o_req.re) |-> (o_req.waddr != o_req.raddr))
        else $error("read and write of one node in a cycle");
    a_full_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && r_o_full) |-> (r_o_node == '0 && !r_o_clone))
        else $error("refused word carries a node");

endmodule
`default_nettype wire

// ===== rtl/core/suffix_automaton_builder.sv =====
`default_nettype none
// Channel   Dir  Ports              Fields (low bit up)
// s_axis    in   tvalid/tready/tdata tdata: symbol[4:0]
// m_axis    out  tvalid/tready/tdata tdata: new_node, new_length, new_link,
//                      /tuser         did_clone, clone_node, node_count; tuser: full_res
//
// One node record (length, link, 26 transitions) per RAM word; one read and one
// write per cycle, so the RAM port sets the pace. An accepted symbol walks the
// suffix links until the root or an existing edge, clones that edge's target when
// its length does not match and redirects matching edges to the clone, then writes the new node.
// Refused or out-of-range symbols skip the walk. After reset the root record is
// written before s_axis is ready; ready is low from accept until the word is taken.
module suffix_automaton_builder (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_s_tvalid,
    output logic                             o_s_tready,
    input  wire logic [sam_pkg::InDataW-1:0] i_s_tdata,   // [4:0] symbol
    output logic                             o_m_tvalid,
    input  wire logic                        i_m_tready,
    // [12:0] new_node, [25:13] new_length, [38:26] new_link, [39] did_clone,
    // [52:40] clone_node, [65:53] node_count
    output logic [sam_pkg::OutDataW-1:0]     o_m_tdata,
    output logic                             o_m_tuser    // [0] full_res
);

    sam_pkg::t_mem_req req;
    sam_pkg::t_rec     rdata;

    sam_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_req      (req),
        .i_rdata    (rdata)
    );

    sam_node_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (req),
        .o_rdata (rdata)
    );

endmodule
`default_nettype wire
